/* rtl/core/ttl_name_cache_macros.svh */
`ifndef TTL_NAME_CACHE_MACROS_SVH
`define TTL_NAME_CACHE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TTLNC_ASSERT(label_, prop_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop_)) \
    else $error(msg_);

// Property whose consequent must hold in the cycle after the trigger.
`define TTLNC_ASSERT_NEXT(label_, pre_, post_, msg_) \
  label_: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre_) |=> (post_)) \
    else $error(msg_);

`endif

/* rtl/core/ttlnc_pkg.sv */
`default_nettype none

package ttlnc_pkg;

  localparam int unsigned SLOT_COUNT = 8;
  localparam int unsigned SLOT_IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [DATA_W-1:0] POS_TTL_RESET = DATA_W'(60 * 60 * 1000);
  localparam logic [DATA_W-1:0] NEG_TTL_RESET = DATA_W'(30 * 1000);

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT        = 3'd0,
    ST_SUPPRESSED = 3'd1,
    ST_MISS       = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_REC_OK     = 3'd4,
    ST_REC_FAIL   = 3'd5
  } status_e;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_RECORD = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_TTL = 1'b0,
    CFG_NEG_TTL = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_FINISH
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic key_empty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/ttlnc_in_if.sv */
`default_nettype none

interface ttlnc_in_if;
  import ttlnc_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [DATA_W-1:0] host_key;
  logic [DATA_W-1:0] now_ms;
  logic              resolved_ok;
  logic [DATA_W-1:0] resolved_address;

  modport source (
    output valid, action, host_key, now_ms, resolved_ok, resolved_address,
    input  ready
  );

  modport sink (
    input  valid, action, host_key, now_ms, resolved_ok, resolved_address,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/ttlnc_out_if.sv */
`default_nettype none

interface ttlnc_out_if;
  import ttlnc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   address;

  modport source (
    output valid, status, address,
    input  ready
  );

  modport sink (
    input  valid, status, address,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/ttlnc_ctrl.sv */
`default_nettype none

module ttlnc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ttlnc_pkg::sts_t  sts_i,
  output ttlnc_pkg::cmd_t  cmd_o
);
  import ttlnc_pkg::*;

`include "ttl_name_cache_macros.svh"

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // empty name needs no walk
          state_d = sts_i.key_empty ? CS_FINISH : CS_SCAN;
        end
      end
      CS_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = CS_FINISH;
        end
      end
      CS_FINISH: begin
        // hold until the result register can take the word
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  `TTLNC_ASSERT_NEXT(a_load_leaves_idle, cmd_o.load, state_q == CS_SCAN || state_q == CS_FINISH, "load did not start work")
  `TTLNC_ASSERT_NEXT(a_scan_ends, state_q == CS_SCAN && sts_i.scan_last, state_q == CS_FINISH, "walk overran last slot")
  `TTLNC_ASSERT_NEXT(a_finish_to_idle, cmd_o.finish, state_q == CS_IDLE, "finish did not return to idle")

endmodule

`default_nettype wire

/* rtl/core/ttlnc_dp.sv */
`default_nettype none

module ttlnc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ttlnc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]         cfg_data_i,
  input  ttlnc_pkg::cmd_t                      cmd_i,
  output ttlnc_pkg::sts_t                      sts_o,
  input  logic                                 action_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]         host_key_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]         now_ms_i,
  input  logic                                 resolved_ok_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]         resolved_address_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ttlnc_pkg::STATUS_W-1:0]       status_o,
  output logic [ttlnc_pkg::DATA_W-1:0]         address_o
);
  import ttlnc_pkg::*;

`include "ttl_name_cache_macros.svh"

  // configuration
  logic [DATA_W-1:0] pos_ttl_q, neg_ttl_q;

  // slot store
  logic [SLOT_COUNT-1:0] used_q;
  logic [DATA_W-1:0]     key_mem_q   [SLOT_COUNT];
  logic [DATA_W-1:0]     addr_mem_q  [SLOT_COUNT];
  logic [DATA_W-1:0]     exp_mem_q   [SLOT_COUNT];
  logic [DATA_W-1:0]     retry_mem_q [SLOT_COUNT];

  // captured word
  action_e           act_q;
  logic [DATA_W-1:0] key_q, now_q, raddr_q;
  logic              ok_q;

  // walk state
  logic [SLOT_IDX_W-1:0] idx_q;
  logic                  match_q, empty_q, minf_q;
  logic [SLOT_IDX_W-1:0] m_idx_q, e_idx_q, min_idx_q;
  logic [DATA_W-1:0]     m_exp_q, m_retry_q, m_addr_q, min_q;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [DATA_W-1:0]   address_q;

  logic                  rd_used;
  logic [DATA_W-1:0]     rd_exp, rd_retry, rd_later;
  logic                  key_match;
  logic [SLOT_IDX_W-1:0] pick_idx;
  logic                  do_write;
  status_e               status_d;
  logic [DATA_W-1:0]     address_d;

  always_comb begin
    rd_used   = used_q[idx_q];
    rd_exp    = exp_mem_q[idx_q];
    rd_retry  = retry_mem_q[idx_q];
    rd_later  = (rd_exp > rd_retry) ? rd_exp : rd_retry;
    key_match = rd_used && (key_mem_q[idx_q] == key_q);
    pick_idx  = match_q ? m_idx_q : (empty_q ? e_idx_q : min_idx_q);
    do_write  = cmd_i.finish && (act_q == ACT_RECORD) && (key_q != '0);
  end

  always_comb begin
    address_d = '0;
    if (key_q == '0) begin
      status_d = ST_EMPTY;
    end else if (act_q == ACT_LOOKUP) begin
      if (match_q && m_exp_q != '0 && now_q < m_exp_q) begin
        status_d  = ST_HIT;
        address_d = m_addr_q;
      end else if (match_q && m_retry_q != '0 && now_q < m_retry_q) begin
        status_d = ST_SUPPRESSED;
      end else begin
        status_d = ST_MISS;
      end
    end else if (ok_q) begin
      status_d  = ST_REC_OK;
      address_d = raddr_q;
    end else begin
      status_d = ST_REC_FAIL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_ttl_q <= POS_TTL_RESET;
      neg_ttl_q <= NEG_TTL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_POS_TTL: pos_ttl_q <= cfg_data_i;
        CFG_NEG_TTL: neg_ttl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (do_write) begin
      used_q[pick_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      key_mem_q[pick_idx]   <= key_q;
      addr_mem_q[pick_idx]  <= ok_q ? raddr_q : '0;
      exp_mem_q[pick_idx]   <= ok_q ? now_q + pos_ttl_q : '0;
      retry_mem_q[pick_idx] <= ok_q ? '0 : now_q + neg_ttl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_e'(action_i);
      key_q   <= host_key_i;
      now_q   <= now_ms_i;
      ok_q    <= resolved_ok_i;
      raddr_q <= resolved_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      match_q <= 1'b0;
      empty_q <= 1'b0;
      minf_q  <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q   <= '0;
      match_q <= 1'b0;
      empty_q <= 1'b0;
      minf_q  <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
      if (key_match) begin
        match_q <= 1'b1;
      end
      if (!rd_used) begin
        empty_q <= 1'b1;
      end
      if (rd_used) begin
        minf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (key_match && !match_q) begin
        m_idx_q   <= idx_q;
        m_exp_q   <= rd_exp;
        m_retry_q <= rd_retry;
        m_addr_q  <= addr_mem_q[idx_q];
      end
      if (!rd_used && !empty_q) begin
        e_idx_q <= idx_q;
      end
      // strict compare keeps the lowest slot on ties
      if (rd_used && (!minf_q || rd_later < min_q)) begin
        min_q     <= rd_later;
        min_idx_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q  <= status_d;
      address_q <= address_d;
    end
  end

  assign sts_o.key_empty = (host_key_i == '0);
  assign sts_o.scan_last = (idx_q == SLOT_IDX_W'(SLOT_COUNT - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign address_o   = address_q;

  `TTLNC_ASSERT(a_finish_into_free, !cmd_i.finish || !out_valid_q || out_ready_i, "result word overwritten")
  `TTLNC_ASSERT(a_single_cmd, $onehot0({cmd_i.load, cmd_i.step, cmd_i.finish}), "overlapping commands")
  `TTLNC_ASSERT_NEXT(a_used_grows, 1'b1, $countones(used_q) >= $past($countones(used_q)), "slot lost its used bit")

endmodule

`default_nettype wire

/* rtl/core/ttl_name_cache.sv */
// Flow: an accepted word is loaded, the walk visits every slot, then the result is written;
//   a word with an empty name skips the walk. A held result word stalls the finish step.
// Words are handled one at a time (an empty name skips the walk); the pace is set by the slot
//   walk, which reads one slot per cycle through a single match/empty/oldest compare unit;
//   a new word is taken while the previous result still waits in the output register.
// Reset (async, active low) clears used bits, controller, output valid; loads default TTLs.
`default_nettype none

module ttl_name_cache (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ttlnc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]    cfg_data_i,
  ttlnc_in_if.sink                        in_i,
  ttlnc_out_if.source                     out_o
);
  import ttlnc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ttlnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttlnc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .action_i           (in_i.action),
    .host_key_i         (in_i.host_key),
    .now_ms_i           (in_i.now_ms),
    .resolved_ok_i      (in_i.resolved_ok),
    .resolved_address_i (in_i.resolved_address),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .status_o           (out_o.status),
    .address_o          (out_o.address)
  );

endmodule

`default_nettype wire

/* verif/ttlnc_checker.sv */
module ttlnc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ttlnc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            in_action_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]    in_key_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]    in_now_i,
  input  logic                            in_ok_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]    in_addr_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [ttlnc_pkg::STATUS_W-1:0]  out_status_i,
  input  logic [ttlnc_pkg::DATA_W-1:0]    out_address_i,
  output int unsigned                     pending_o,
  output int unsigned                     fail_count_o
);
  import ttlnc_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] address;
  } answer_t;

  logic [DATA_W-1:0] pos_ttl;
  logic [DATA_W-1:0] neg_ttl;
  logic              used_mem   [SLOT_COUNT];
  logic [DATA_W-1:0] key_mem    [SLOT_COUNT];
  logic [DATA_W-1:0] addr_mem   [SLOT_COUNT];
  logic [DATA_W-1:0] expiry_mem [SLOT_COUNT];
  logic [DATA_W-1:0] retry_mem  [SLOT_COUNT];

  answer_t     answer_q [$];
  answer_t     oldest;
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatches < 100)
      $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, want);
    mismatches++;
  endtask

  function automatic int find_key(input logic [DATA_W-1:0] key);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (used_mem[i] && key_mem[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [DATA_W-1:0] latest_time(input int i);
    return (expiry_mem[i] > retry_mem[i]) ? expiry_mem[i] : retry_mem[i];
  endfunction

  // Match first, then the lowest free slot, then the lowest slot with the
  // earliest of its later times.
  function automatic int claim_slot(input logic [DATA_W-1:0] key);
    int pick;
    pick = find_key(key);
    if (pick >= 0) return pick;
    for (int i = 0; i < SLOT_COUNT; i++)
      if (!used_mem[i] && pick < 0) pick = i;
    if (pick < 0) begin
      pick = 0;
      for (int i = 1; i < SLOT_COUNT; i++)
        if (latest_time(i) < latest_time(pick)) pick = i;
    end
    used_mem[pick]   = 1'b1;
    key_mem[pick]    = key;
    addr_mem[pick]   = '0;
    expiry_mem[pick] = '0;
    retry_mem[pick]  = '0;
    return pick;
  endfunction

  function automatic answer_t cache_answer(input logic act, input logic [DATA_W-1:0] key,
                                           input logic [DATA_W-1:0] now, input logic ok,
                                           input logic [DATA_W-1:0] addr);
    answer_t ans;
    int      s;
    ans.status  = ST_MISS;
    ans.address = '0;
    if (key == '0) begin
      ans.status = ST_EMPTY;
    end else if (act == ACT_LOOKUP) begin
      s = find_key(key);
      if (s >= 0 && expiry_mem[s] != '0 && now < expiry_mem[s]) begin
        ans.status  = ST_HIT;
        ans.address = addr_mem[s];
      end else if (s >= 0 && retry_mem[s] != '0 && now < retry_mem[s]) begin
        ans.status = ST_SUPPRESSED;
      end
    end else begin
      s = claim_slot(key);
      if (ok) begin
        addr_mem[s]   = addr;
        expiry_mem[s] = now + pos_ttl;
        retry_mem[s]  = '0;
        ans.status    = ST_REC_OK;
        ans.address   = addr;
      end else begin
        expiry_mem[s] = '0;
        retry_mem[s]  = now + neg_ttl;
        ans.status    = ST_REC_FAIL;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_ttl = POS_TTL_RESET;
      neg_ttl = NEG_TTL_RESET;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        used_mem[i]   = 1'b0;
        key_mem[i]    = '0;
        addr_mem[i]   = '0;
        expiry_mem[i] = '0;
        retry_mem[i]  = '0;
      end
      answer_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POS_TTL) pos_ttl = cfg_data_i;
        else if (cfg_idx_i == CFG_NEG_TTL) neg_ttl = cfg_data_i;
      end
      // retire the result before taking the next word; both can come in the same cycle
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result word with nothing expected, status",
                          DATA_W'(out_status_i), '0);
        end else begin
          oldest = answer_q.pop_front();
          if (out_status_i !== oldest.status)
            report_mismatch("status", DATA_W'(out_status_i), DATA_W'(oldest.status));
          if (out_address_i !== oldest.address)
            report_mismatch("address", out_address_i, oldest.address);
        end
      end
      if (in_valid_i && in_ready_i)
        answer_q.push_back(cache_answer(in_action_i, in_key_i, in_now_i, in_ok_i, in_addr_i));
      pending_o <= answer_q.size();
    end
  end

endmodule

/* verif/tb.sv */
module tb;
  import ttlnc_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;
  logic                 drain_hold = 1'b0;
  int unsigned          pending;
  int unsigned          fail_count;
  int unsigned          words_sent = 0;
  logic [DATA_W-1:0]    key_pool [12];
  logic [DATA_W-1:0]    clock_ms;

  ttlnc_in_if  req_if ();
  ttlnc_out_if rsp_if ();

  ttl_name_cache u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  ttlnc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (req_if.valid),
    .in_ready_i    (req_if.ready),
    .in_action_i   (req_if.action),
    .in_key_i      (req_if.host_key),
    .in_now_i      (req_if.now_ms),
    .in_ok_i       (req_if.resolved_ok),
    .in_addr_i     (req_if.resolved_address),
    .out_valid_i   (rsp_if.valid),
    .out_ready_i   (rsp_if.ready),
    .out_status_i  (rsp_if.status),
    .out_address_i (rsp_if.address),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  // Offer one word after a random gap; return at the edge that takes it.
  task automatic send_word(input action_e act, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] now, input logic ok,
                           input logic [DATA_W-1:0] addr);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.action           <= act;
    req_if.host_key         <= key;
    req_if.now_ms           <= now;
    req_if.resolved_ok      <= ok;
    req_if.resolved_address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_ttls(input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] neg);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_POS_TTL;
    cfg_data <= pos;
    @(posedge clk_i);
    cfg_idx  <= CFG_NEG_TTL;
    cfg_data <= neg;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] neg,
                           input int unsigned step_max, input int unsigned count);
    int unsigned       r;
    action_e           act;
    logic [DATA_W-1:0] key;
    wait_idle();
    set_ttls(pos, neg);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 4) clock_ms = $urandom;
      else if (r < 6) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 4);
      else clock_ms = clock_ms + $urandom_range(0, step_max);
      r = $urandom_range(0, 99);
      if (r < 5) key = '0;
      else if (r < 15) key = $urandom;
      else key = key_pool[$urandom_range(0, 11)];
      act = ($urandom_range(0, 9) < 4) ? ACT_RECORD : ACT_LOOKUP;
      send_word(act, key, clock_ms, $urandom_range(0, 3) != 0, $urandom);
    end
  endtask

  // Result side: random gaps, plus the long hold-off when asked.
  initial begin
    int unsigned gap;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, 3);
      if (gap != 0 || drain_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (drain_hold) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  // Stall the result side long enough that the block backs up its input.
  initial begin
    wait (words_sent >= 100);
    @(posedge clk_i);
    drain_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    drain_hold <= 1'b0;
  end

  initial begin
    int unsigned tail;
    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= CFG_POS_TTL;
    cfg_data                <= '0;
    req_if.valid            <= 1'b0;
    req_if.action           <= ACT_LOOKUP;
    req_if.host_key         <= '0;
    req_if.now_ms           <= '0;
    req_if.resolved_ok      <= 1'b0;
    req_if.resolved_address <= '0;
    for (int i = 0; i < 12; i++)
      do key_pool[i] = $urandom; while (key_pool[i] == '0);
    clock_ms = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, default lifetimes
    send_word(ACT_LOOKUP, '0, '0, 1'b1, 32'hFFFF_FFFF);
    send_word(ACT_RECORD, '0, 32'hFFFF_FFFF, 1'b1, 32'h0A00_0001);
    send_word(ACT_LOOKUP, 32'h0000_0001, 32'd0, 1'b0, '0);
    send_word(ACT_RECORD, 32'h0000_0001, 32'd0, 1'b1, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'h0000_0001, 32'd3599999, 1'b0, '0);
    send_word(ACT_LOOKUP, 32'h0000_0001, 32'd3600000, 1'b0, '0);
    // failure over a success drops the stored address; a lookup never reports it
    send_word(ACT_RECORD, 32'h0000_0001, 32'd1000, 1'b0, 32'h1234_5678);
    send_word(ACT_LOOKUP, 32'h0000_0001, 32'd30999, 1'b0, '0);
    send_word(ACT_LOOKUP, 32'h0000_0001, 32'd31000, 1'b0, '0);
    // expiry and retry time that land exactly on zero
    send_word(ACT_RECORD, 32'hFFFF_FFFF, 32'hFFC9_1180, 1'b1, '0);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd0, 1'b0, '0);
    send_word(ACT_RECORD, 32'h0000_0003, 32'hFFFF_8AD0, 1'b0, '0);
    send_word(ACT_LOOKUP, 32'h0000_0003, 32'd1, 1'b0, '0);
    // expiry wrapped past the top reads as expired at a large now
    send_word(ACT_RECORD, 32'h0000_0004, 32'hFFFF_FFF0, 1'b1, 32'hC0A8_0004);
    send_word(ACT_LOOKUP, 32'h0000_0004, 32'hFFFF_FFF8, 1'b0, '0);
    send_word(ACT_LOOKUP, 32'h0000_0004, 32'd5, 1'b0, '0);
    // fill every slot, then evict: tie on the smallest later time
    send_word(ACT_RECORD, 32'h8000_0000, 32'd100, 1'b1, 32'h5555_5555);
    send_word(ACT_RECORD, 32'h5555_5555, 32'd100, 1'b1, 32'hAAAA_AAAA);
    send_word(ACT_RECORD, 32'hAAAA_AAAA, 32'd100, 1'b1, 32'h0000_0001);
    send_word(ACT_RECORD, 32'h0000_FFFF, 32'd100, 1'b1, 32'h8000_0000);
    send_word(ACT_RECORD, 32'h0000_0009, 32'd200, 1'b1, 32'h0909_0909);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'd250, 1'b0, '0);
    send_word(ACT_RECORD, 32'h0000_000A, 32'd300, 1'b0, 32'hFFFF_0000);
    send_word(ACT_LOOKUP, 32'h0000_0009, 32'd300, 1'b0, '0);
    send_word(ACT_LOOKUP, 32'h0000_000A, 32'd301, 1'b0, '0);
    send_word(ACT_RECORD, 32'h0000_0001, 32'd500, 1'b1, 32'h0102_0304);
    send_word(ACT_LOOKUP, 32'h0000_0001, 32'd501, 1'b0, '0);

    // random part over several lifetime settings
    run_phase(32'd200, 32'd80, 40, 300);
    run_phase(32'd1, 32'd1, 2, 150);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 50, 150);
    run_phase($urandom_range(1, 5000), $urandom_range(1, 2000), 500, 200);
    run_phase(32'd0, 32'd0, 10, 100);
    run_phase(POS_TTL_RESET, NEG_TTL_RESET, 20000, 200);

    req_if.valid <= 1'b0;
    tail = 0;
    do begin
      @(posedge clk_i);
      tail++;
    end while (pending != 0 && tail < 5000);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      if (pending != 0) $display("ERROR: %0d result words never arrived", pending);
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ttlnc_pkg.sv
rtl/core/ttlnc_in_if.sv
rtl/core/ttlnc_out_if.sv
rtl/core/ttlnc_ctrl.sv
rtl/core/ttlnc_dp.sv
rtl/core/ttl_name_cache.sv
verif/ttlnc_checker.sv
verif/tb.sv
